// ===== hdl/itra_pkg.sv =====
// Shared types, constants and helpers for the integer to radix ASCII converter.
// No dependencies; every other file refers into this package by scoped name.
package itra_pkg;

    localparam int unsigned VALUE_PORT_W    = 64;
    localparam int unsigned VALUE_WIDTH_DEF = 64;
    localparam int unsigned MAX_DIGITS_DEF  = 64;

    localparam int unsigned RADIX_W     = 6;
    localparam int unsigned CHAR_W      = 7;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 6;

    // Quotient bits resolved per divider cycle
    localparam int unsigned DIV_STEPS = 8;

    localparam int unsigned ITEM_Q_DEPTH = 2;
    localparam int unsigned ITEM_Q_PTR_W = $clog2(ITEM_Q_DEPTH);
    localparam int unsigned ITEM_Q_CNT_W = $clog2(ITEM_Q_DEPTH + 1);

    localparam int unsigned OUT_Q_DEPTH = 4;
    localparam int unsigned OUT_Q_PTR_W = $clog2(OUT_Q_DEPTH);
    localparam int unsigned OUT_Q_CNT_W = $clog2(OUT_Q_DEPTH + 1);

    localparam logic [CFG_INDEX_W-1:0] CFG_RADIX  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOWER  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PREFIX = 2'd2;

    localparam logic [RADIX_W-1:0] RADIX_MIN    = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX    = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET  = 6'd16;
    localparam logic [RADIX_W-1:0] PREFIX_RADIX = 6'd16;
    localparam logic [RADIX_W-1:0] DECIMAL_TOP  = 6'd10;

    localparam logic [CHAR_W-1:0] ASCII_ZERO        = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_LETTER_BASE = 7'd55;
    localparam logic [CHAR_W-1:0] CASE_OFFSET       = 7'd32;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_X     = 7'd120;

    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic               lower;
        logic               prefix;
    } t_item_ctrl;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_PREFIX0,
        BK_PREFIX_X,
        BK_DIGITS
    } t_back_state;

    function automatic logic [CHAR_W-1:0] f_digit_char(input logic [RADIX_W-1:0] d,
                                                       input logic             lower);
        logic [CHAR_W-1:0] c;
        begin
            if (d < DECIMAL_TOP) begin
                c = ASCII_ZERO + CHAR_W'(d);
            end else begin
                c = ASCII_LETTER_BASE + CHAR_W'(d);
                if (lower) begin
                    c = c + CASE_OFFSET;
                end
            end
            return c;
        end
    endfunction

endpackage

// ===== hdl/itra_front.sv =====
// Front end: configuration registers, input acceptance, radix clamping and
// prefix decision, plus the short item queue feeding the back end. Uses itra_pkg.
module itra_front #(
    parameter int unsigned VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    output logic                                 o_full,
    input  logic [itra_pkg::VALUE_PORT_W-1:0]    i_value,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [itra_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [itra_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                 o_item_valid,
    input  logic                                 i_item_take,
    output logic [VALUE_WIDTH-1:0]               o_item_value,
    output itra_pkg::t_item_ctrl                 o_item_ctrl
);

    localparam int unsigned QD  = itra_pkg::ITEM_Q_DEPTH;
    localparam int unsigned PW  = itra_pkg::ITEM_Q_PTR_W;
    localparam int unsigned CW  = itra_pkg::ITEM_Q_CNT_W;

    logic [itra_pkg::RADIX_W-1:0] r_radix;
    logic                         r_lower;
    logic                         r_prefix;

    logic [VALUE_WIDTH-1:0]       r_q_value [QD];
    itra_pkg::t_item_ctrl         r_q_ctrl  [QD];
    logic [PW-1:0]                r_wr_ptr;
    logic [PW-1:0]                r_rd_ptr;
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                n_count;

    logic [itra_pkg::RADIX_W-1:0] w_eff_radix;
    itra_pkg::t_item_ctrl         w_ctrl;
    logic                         w_push_ok;
    logic                         w_take_ok;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= itra_pkg::RADIX_RESET;
            r_lower  <= 1'b1;
            r_prefix <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                itra_pkg::CFG_RADIX:  r_radix  <= i_cfg_data[itra_pkg::RADIX_W-1:0];
                itra_pkg::CFG_LOWER:  r_lower  <= i_cfg_data[0];
                itra_pkg::CFG_PREFIX: r_prefix <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Clamp out-of-range radix values to the nearest legal base
    always_comb begin
        if (r_radix < itra_pkg::RADIX_MIN) begin
            w_eff_radix = itra_pkg::RADIX_MIN;
        end else if (r_radix > itra_pkg::RADIX_MAX) begin
            w_eff_radix = itra_pkg::RADIX_MAX;
        end else begin
            w_eff_radix = r_radix;
        end
        w_ctrl.radix  = w_eff_radix;
        w_ctrl.lower  = r_lower;
        w_ctrl.prefix = r_prefix && (w_eff_radix == itra_pkg::PREFIX_RADIX);
    end

    assign o_full       = (r_count == CW'(QD));
    assign o_item_valid = (r_count != '0);
    assign w_push_ok    = i_push && !o_full;
    assign w_take_ok    = i_item_take && o_item_valid;

    always_comb begin
        n_count = r_count;
        if (w_push_ok && !w_take_ok) begin
            n_count = r_count + 1'b1;
        end else if (!w_push_ok && w_take_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_take_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_q_value[r_wr_ptr] <= i_value[VALUE_WIDTH-1:0];
            r_q_ctrl[r_wr_ptr]  <= w_ctrl;
        end
    end

    assign o_item_value = r_q_value[r_rd_ptr];
    assign o_item_ctrl  = r_q_ctrl[r_rd_ptr];

endmodule

// ===== hdl/itra_div_unit.sv =====
// Multi-cycle divider of an unsigned value by a 6-bit radix, restoring long
// division resolving DIV_STEPS quotient bits per cycle. Uses itra_pkg.
module itra_div_unit #(
    parameter int unsigned VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [VALUE_WIDTH-1:0]        i_dividend,
    input  logic [itra_pkg::RADIX_W-1:0]  i_divisor,
    output logic                          o_done,
    output logic [VALUE_WIDTH-1:0]        o_quotient,
    output logic [itra_pkg::RADIX_W-1:0]  o_remainder
);

    localparam int unsigned STEPS      = itra_pkg::DIV_STEPS;
    localparam int unsigned RW         = itra_pkg::RADIX_W;
    localparam int unsigned DIV_CYCLES = (VALUE_WIDTH + STEPS - 1) / STEPS;
    localparam int unsigned PAD_W      = DIV_CYCLES * STEPS;
    localparam int unsigned CYC_W      = $clog2(DIV_CYCLES + 1);

    logic [PAD_W-1:0] r_shift;
    logic [RW-1:0]    r_rem;
    logic [RW-1:0]    r_divisor;
    logic [CYC_W-1:0] r_cyc;
    logic             r_busy;
    logic             r_done;

    logic [RW-1:0]    w_rem;
    logic [RW:0]      w_trial;
    logic [STEPS-1:0] w_qbits;

    // Dividend bits are consumed from the top; quotient bits fill in from the bottom
    always_comb begin
        w_rem   = r_rem;
        w_trial = '0;
        w_qbits = '0;
        for (int k = 0; k < STEPS; k++) begin
            w_trial = {w_rem, r_shift[PAD_W-1-k]};
            if (w_trial >= {1'b0, r_divisor}) begin
                w_trial            = w_trial - {1'b0, r_divisor};
                w_qbits[STEPS-1-k] = 1'b1;
            end
            w_rem = w_trial[RW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cyc  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cyc  <= '0;
            end else if (r_busy) begin
                r_cyc <= r_cyc + 1'b1;
                if (r_cyc == CYC_W'(DIV_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_shift   <= PAD_W'(i_dividend);
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_shift <= (r_shift << STEPS) | PAD_W'(w_qbits);
            r_rem   <= w_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_shift[VALUE_WIDTH-1:0];
    assign o_remainder = r_rem;

endmodule

// ===== hdl/itra_back.sv =====
// Back end: divides digit by digit into the digit store, then emits the optional 0x prefix and
// the digits, most significant first, into the result queue. Uses itra_pkg, itra_div_unit.
module itra_back #(
    parameter int unsigned VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEF,
    parameter int unsigned MAX_DIGITS  = itra_pkg::MAX_DIGITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_item_valid,
    output logic                              o_item_take,
    input  logic [VALUE_WIDTH-1:0]            i_item_value,
    input  itra_pkg::t_item_ctrl              i_item_ctrl,
    output logic                              o_empty,
    input  logic                              i_pop,
    output logic [itra_pkg::CHAR_W-1:0]       o_char_code,
    output logic                              o_last_char
);

    localparam int unsigned RW  = itra_pkg::RADIX_W;
    localparam int unsigned CHW = itra_pkg::CHAR_W;
    localparam int unsigned AW  = $clog2(MAX_DIGITS);
    localparam int unsigned CW  = $clog2(MAX_DIGITS + 1);
    localparam int unsigned OQD = itra_pkg::OUT_Q_DEPTH;
    localparam int unsigned OPW = itra_pkg::OUT_Q_PTR_W;
    localparam int unsigned OCW = itra_pkg::OUT_Q_CNT_W;

    itra_pkg::t_back_state r_state;
    itra_pkg::t_back_state n_state;
    itra_pkg::t_item_ctrl  r_ctrl;

    logic [CW-1:0]  r_count;
    logic [AW-1:0]  r_rd_idx;
    logic [RW-1:0]  r_store [MAX_DIGITS];
    logic [RW-1:0]  r_rd_data;

    logic           r_s1_valid;
    logic           r_s1_prefix;
    logic [CHW-1:0] r_s1_char;
    logic           r_s1_last;
    logic           r_s1_lower;

    logic [CHW-1:0] r_oq_char [OQD];
    logic           r_oq_last [OQD];
    logic [OPW-1:0] r_oq_wr;
    logic [OPW-1:0] r_oq_rd;
    logic [OCW-1:0] r_oq_count;

    logic                   w_div_start;
    logic                   w_div_src_q;
    logic [VALUE_WIDTH-1:0] w_div_dividend;
    logic                   w_div_done;
    logic [VALUE_WIDTH-1:0] w_div_quotient;
    logic [RW-1:0]          w_div_rem;
    logic                   w_q_nonzero;

    logic           w_store_we;
    logic [CW-1:0]  w_final;
    logic [CW-1:0]  w_final_m1;
    logic           w_room;
    logic           w_issue;
    logic           w_issue_prefix;
    logic [CHW-1:0] w_issue_char;
    logic           w_issue_last;
    logic [CHW-1:0] w_push_char;
    logic           w_pop_ok;

    assign w_div_dividend = w_div_src_q ? w_div_quotient : i_item_value;

    itra_div_unit #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_div_dividend),
        .i_divisor   (w_div_src_q ? r_ctrl.radix : i_item_ctrl.radix),
        .o_done      (w_div_done),
        .o_quotient  (w_div_quotient),
        .o_remainder (w_div_rem)
    );

    assign w_q_nonzero = (w_div_quotient != '0);
    assign w_final     = r_count + CW'(w_store_we);
    assign w_final_m1  = w_final - 1'b1;

    // Count the entry in flight in the read stage against queue space
    assign w_room = (r_oq_count + OCW'(r_s1_valid)) < OCW'(OQD);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            itra_pkg::BK_IDLE: begin
                if (i_item_valid) begin
                    n_state = itra_pkg::BK_DIVIDE;
                end
            end
            itra_pkg::BK_DIVIDE: begin
                if (w_div_done && !w_q_nonzero) begin
                    n_state = r_ctrl.prefix ? itra_pkg::BK_PREFIX0 : itra_pkg::BK_DIGITS;
                end
            end
            itra_pkg::BK_PREFIX0: begin
                if (w_room) begin
                    n_state = itra_pkg::BK_PREFIX_X;
                end
            end
            itra_pkg::BK_PREFIX_X: begin
                if (w_room) begin
                    n_state = itra_pkg::BK_DIGITS;
                end
            end
            itra_pkg::BK_DIGITS: begin
                if (w_room && (r_rd_idx == '0)) begin
                    n_state = itra_pkg::BK_IDLE;
                end
            end
            default: n_state = itra_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_item_take    = 1'b0;
        w_div_start    = 1'b0;
        w_div_src_q    = 1'b0;
        w_store_we     = 1'b0;
        w_issue        = 1'b0;
        w_issue_prefix = 1'b0;
        w_issue_char   = itra_pkg::ASCII_ZERO;
        w_issue_last   = 1'b0;
        unique case (r_state)
            itra_pkg::BK_IDLE: begin
                if (i_item_valid) begin
                    o_item_take = 1'b1;
                    w_div_start = 1'b1;
                end
            end
            itra_pkg::BK_DIVIDE: begin
                if (w_div_done) begin
                    // Past the store depth only the low-order digits are kept
                    w_store_we = (r_count < CW'(MAX_DIGITS));
                    if (w_q_nonzero) begin
                        w_div_start = 1'b1;
                        w_div_src_q = 1'b1;
                    end
                end
            end
            itra_pkg::BK_PREFIX0: begin
                if (w_room) begin
                    w_issue        = 1'b1;
                    w_issue_prefix = 1'b1;
                    w_issue_char   = itra_pkg::ASCII_ZERO;
                end
            end
            itra_pkg::BK_PREFIX_X: begin
                if (w_room) begin
                    w_issue        = 1'b1;
                    w_issue_prefix = 1'b1;
                    w_issue_char   = itra_pkg::ASCII_LOWER_X;
                end
            end
            itra_pkg::BK_DIGITS: begin
                if (w_room) begin
                    w_issue      = 1'b1;
                    w_issue_last = (r_rd_idx == '0);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= itra_pkg::BK_IDLE;
            r_count    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_s1_valid <= w_issue;
            if (o_item_take) begin
                r_count <= '0;
            end else if (w_store_we) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_take) begin
            r_ctrl <= i_item_ctrl;
        end
        if (w_div_done && !w_q_nonzero) begin
            r_rd_idx <= w_final_m1[AW-1:0];
        end else if (w_issue && !w_issue_prefix) begin
            r_rd_idx <= r_rd_idx - 1'b1;
        end
        if (w_issue) begin
            r_s1_prefix <= w_issue_prefix;
            r_s1_char   <= w_issue_char;
            r_s1_last   <= w_issue_last;
            r_s1_lower  <= r_ctrl.lower;
        end
    end

    // Digit store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_store_we) begin
            r_store[r_count[AW-1:0]] <= w_div_rem;
        end
        if (w_issue && !w_issue_prefix) begin
            r_rd_data <= r_store[r_rd_idx];
        end
    end

    assign w_push_char = r_s1_prefix ? r_s1_char
                                     : itra_pkg::f_digit_char(r_rd_data, r_s1_lower);

    assign o_empty  = (r_oq_count == '0);
    assign w_pop_ok = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr    <= '0;
            r_oq_rd    <= '0;
            r_oq_count <= '0;
        end else begin
            if (r_s1_valid) begin
                r_oq_wr <= r_oq_wr + 1'b1;
            end
            if (w_pop_ok) begin
                r_oq_rd <= r_oq_rd + 1'b1;
            end
            if (r_s1_valid && !w_pop_ok) begin
                r_oq_count <= r_oq_count + 1'b1;
            end else if (!r_s1_valid && w_pop_ok) begin
                r_oq_count <= r_oq_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_oq_char[r_oq_wr] <= w_push_char;
            r_oq_last[r_oq_wr] <= r_s1_last;
        end
    end

    assign o_char_code = r_oq_char[r_oq_rd];
    assign o_last_char = r_oq_last[r_oq_rd];

endmodule

// ===== hdl/integer_to_radix_ascii_core.sv =====
// An accepted value waits in the item queue until the back end takes it and starts the
// shared radix divider; each digit costs one division, then the prefix and digits leave
// one character per cycle while the result queue has room. The back end finishes one
// value before it takes the next, while the item queue holds up to two more values.
// Reset (synchronous, active low) empties both queues and sets radix 16, lower case
// letters and the 0x prefix; digit store kept.
module integer_to_radix_ascii_core #(
    parameter int unsigned VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEF,
    parameter int unsigned MAX_DIGITS  = itra_pkg::MAX_DIGITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [itra_pkg::VALUE_PORT_W-1:0]   i_value,
    output logic                                empty,
    input  logic                                pop,
    output logic [itra_pkg::CHAR_W-1:0]         o_char_code,
    output logic                                o_last_char,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [itra_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [itra_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic                   w_item_valid;
    logic                   w_item_take;
    logic [VALUE_WIDTH-1:0] w_item_value;
    itra_pkg::t_item_ctrl   w_item_ctrl;

    itra_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_value      (i_value),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_item_valid (w_item_valid),
        .i_item_take  (w_item_take),
        .o_item_value (w_item_value),
        .o_item_ctrl  (w_item_ctrl)
    );

    itra_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .o_item_take  (w_item_take),
        .i_item_value (w_item_value),
        .i_item_ctrl  (w_item_ctrl),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_char_code  (o_char_code),
        .o_last_char  (o_last_char)
    );

endmodule

// ===== hdl/itra_checker.sv =====
// Port-level checks for integer_to_radix_ascii_core, attached with bind.
// Depends on itra_pkg and on the top level's port names.
module itra_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              push,
    input logic                              full,
    input logic [itra_pkg::VALUE_PORT_W-1:0] i_value,
    input logic                              empty,
    input logic                              pop,
    input logic [itra_pkg::CHAR_W-1:0]       o_char_code,
    input logic                              o_last_char,
    input logic                              i_cfg_valid,
    input logic                              o_cfg_ready,
    input logic [itra_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input logic [itra_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // Reset drains both queues
    a_reset_drains: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // The input queue fills only on a push transfer
    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !push |=> !$rose(full))
        else $error("full rose without a push");

    // A waiting result holds until it is taken
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_char_code) && $stable(o_last_char))
        else $error("waiting result changed");

    // Every visible character is a digit or a letter ('x' of the prefix included)
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_char_code >= 7'd48 && o_char_code <= 7'd57) ||
                   (o_char_code >= 7'd65 && o_char_code <= 7'd90) ||
                   (o_char_code >= 7'd97 && o_char_code <= 7'd122))
        else $error("illegal character code");

endmodule

bind integer_to_radix_ascii_core itra_checker u_itra_checker (.*);

// ===== tb/sv/tb_integer_to_radix_ascii_core.sv =====
// Self-checking testbench for integer_to_radix_ascii_core: directed and random values
// across radix, letter case and prefix settings, checked against an in-bench predictor.
// Depends on itra_pkg and the core RTL only.
module tb_integer_to_radix_ascii_core;

    localparam logic [itra_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int RAND_PHASES     = 9;
    localparam int ITEMS_PER_PHASE = 11;
    localparam int HOLD_CYCLES     = 600;
    localparam int TAIL_CYCLES     = 700;
    localparam int WATCHDOG_LIMIT  = 4000;

    typedef enum logic {
        PACE_FULL,
        PACE_RANDOM
    } t_pace;

    typedef struct packed {
        logic [itra_pkg::CHAR_W-1:0] code;
        logic                        last;
    } t_glyph;

    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              push        = 1'b0;
    logic                              full;
    logic [itra_pkg::VALUE_PORT_W-1:0] i_value     = '0;
    logic                              empty;
    logic                              pop         = 1'b0;
    logic [itra_pkg::CHAR_W-1:0]       o_char_code;
    logic                              o_last_char;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [itra_pkg::CFG_INDEX_W-1:0]  i_cfg_index = '0;
    logic [itra_pkg::CFG_DATA_W-1:0]   i_cfg_data  = '0;

    // Predictor copy of the configuration registers
    logic [itra_pkg::RADIX_W-1:0] cur_radix  = itra_pkg::RADIX_RESET;
    logic                         cur_lower  = 1'b1;
    logic                         cur_prefix = 1'b1;

    logic [itra_pkg::VALUE_PORT_W-1:0] pending_values [$];
    t_glyph                            expected_chars [$];

    t_pace pace        = PACE_FULL;
    int    hold_token  = 0;
    int    hold_seen   = 0;
    int    send_gap    = 0;
    int    stall_left  = 0;
    int    values_sent = 0;
    int    chars_seen  = 0;
    int    reg_writes  = 0;
    int    phases      = 0;
    int    mismatches  = 0;

    integer_to_radix_ascii_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_value     (i_value),
        .empty       (empty),
        .pop         (pop),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 19) < 15) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Queue the characters the core must emit for one value under the current settings
    function automatic void spell_value(input logic [itra_pkg::VALUE_PORT_W-1:0] v);
        logic [itra_pkg::RADIX_W-1:0]      base;
        logic [itra_pkg::RADIX_W-1:0]      digits [$];
        logic [itra_pkg::VALUE_PORT_W-1:0] rest;
        t_glyph                            g;
        if (cur_radix < itra_pkg::RADIX_MIN) begin
            base = itra_pkg::RADIX_MIN;
        end else if (cur_radix > itra_pkg::RADIX_MAX) begin
            base = itra_pkg::RADIX_MAX;
        end else begin
            base = cur_radix;
        end
        rest = v;
        do begin
            digits.push_front(itra_pkg::RADIX_W'(rest % itra_pkg::VALUE_PORT_W'(base)));
            rest = rest / itra_pkg::VALUE_PORT_W'(base);
        end while (rest != 0);
        if (cur_prefix && base == itra_pkg::PREFIX_RADIX) begin
            expected_chars.push_back('{code: itra_pkg::ASCII_ZERO, last: 1'b0});
            expected_chars.push_back('{code: itra_pkg::ASCII_LOWER_X, last: 1'b0});
        end
        foreach (digits[i]) begin
            if (digits[i] < itra_pkg::DECIMAL_TOP) begin
                g.code = 7'h30 + itra_pkg::CHAR_W'(digits[i]);
            end else begin
                g.code = (cur_lower ? 7'h61 : 7'h41) + itra_pkg::CHAR_W'(digits[i]) - 7'd10;
            end
            g.last = (i == digits.size() - 1);
            expected_chars.push_back(g);
        end
    endfunction

    // Input driver: offer queued values, with optional gaps between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                spell_value(i_value);
                values_sent++;
            end
            if (!push || !full) begin
                if (send_gap > 0) begin
                    send_gap--;
                    push <= 1'b0;
                end else if (pending_values.size() != 0) begin
                    i_value <= pending_values.pop_front();
                    push    <= 1'b1;
                    if (pace == PACE_RANDOM && $urandom_range(0, 1) == 0) begin
                        send_gap = gap_len();
                    end
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each transfer, stall pop at random or on a hold request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                chars_seen++;
                if (expected_chars.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected character: expected none, got %02h last %0b",
                             $time, o_char_code, o_last_char);
                end else begin
                    t_glyph exp_g;
                    exp_g = expected_chars.pop_front();
                    if (o_char_code !== exp_g.code) begin
                        mismatches++;
                        $display("%0t: char_code mismatch: expected %02h, got %02h",
                                 $time, exp_g.code, o_char_code);
                    end
                    if (o_last_char !== exp_g.last) begin
                        mismatches++;
                        $display("%0t: last_char mismatch: expected %0b, got %0b",
                                 $time, exp_g.last, o_last_char);
                    end
                end
            end
            if (hold_token != hold_seen) begin
                hold_seen  = hold_token;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else if (pace == PACE_RANDOM && $urandom_range(0, 3) == 0) begin
                stall_left = gap_len() - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Abort if nothing transfers on any channel for too long
    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
                stuck = 0;
            end else begin
                stuck++;
            end
        end
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb_integer_to_radix_ascii_core NOT OK");
        $finish;
    end

    // Wait until every queued value has gone in and every character has come out
    task automatic settle();
        @(negedge i_clk);
        while (pending_values.size() != 0 || push || expected_chars.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Drain, then write all registers (and optionally the unused index) while idle
    task automatic start_phase(input logic [itra_pkg::CFG_DATA_W-1:0] rdx,
                               input logic [itra_pkg::CFG_DATA_W-1:0] lc,
                               input logic [itra_pkg::CFG_DATA_W-1:0] pf,
                               input bit                              stray,
                               input t_pace                           p);
        logic [itra_pkg::CFG_INDEX_W-1:0] idx [4];
        logic [itra_pkg::CFG_DATA_W-1:0]  dat [4];
        int                               n;
        idx = '{itra_pkg::CFG_RADIX, itra_pkg::CFG_LOWER, itra_pkg::CFG_PREFIX, CFG_UNUSED};
        dat = '{rdx, lc, pf, itra_pkg::CFG_DATA_W'($urandom)};
        n   = stray ? 4 : 3;
        settle();
        @(posedge i_clk);
        for (int k = 0; k < n; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= dat[k];
            @(posedge i_clk);
            while (!o_cfg_ready) begin
                @(posedge i_clk);
            end
            case (idx[k])
                itra_pkg::CFG_RADIX:  cur_radix  = dat[k];
                itra_pkg::CFG_LOWER:  cur_lower  = dat[k][0];
                itra_pkg::CFG_PREFIX: cur_prefix = dat[k][0];
                default: ;
            endcase
            reg_writes++;
        end
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
        pace = p;
        phases++;
    endtask

    initial begin
        logic [itra_pkg::VALUE_PORT_W-1:0] v;
        logic [itra_pkg::CFG_DATA_W-1:0]   rdx;
        int                                sel;
        int                                kind;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: hex, lower case, 0x prefix
        @(negedge i_clk);
        pending_values = '{64'd0, 64'd1, 64'd15, 64'hDEAD_BEEF_CAFE_F00D, '1};

        // Binary: longest strings; register data with high bits set
        start_phase(6'd2, 6'h3E, 6'h3F, 1'b0, PACE_RANDOM);
        pending_values = '{64'd0, '1, 64'h8000_0000_0000_0000};

        // Top radix, lower case, write to the unused index
        start_phase(6'd36, 6'h01, 6'h00, 1'b1, PACE_FULL);
        pending_values = '{64'd35, '1, 64'd36};

        // Radix below two acts as binary
        start_phase(6'd0, 6'h00, 6'h01, 1'b0, PACE_FULL);
        pending_values.push_back(64'd5);
        start_phase(6'd1, 6'h00, 6'h01, 1'b0, PACE_RANDOM);
        pending_values.push_back(64'd6);

        // Radix above thirty-six acts as thirty-six
        start_phase(6'd63, 6'h00, 6'h01, 1'b0, PACE_FULL);
        pending_values = '{64'd35, 64'd71};
        start_phase(6'd37, 6'h3F, 6'h01, 1'b0, PACE_FULL);
        pending_values.push_back(64'd36);

        // Decimal ignores the prefix
        start_phase(6'd10, 6'h00, 6'h01, 1'b0, PACE_RANDOM);
        pending_values = '{64'd0, '1};

        // Hex without prefix, then with prefix in upper case
        start_phase(6'd16, 6'h00, 6'h00, 1'b0, PACE_FULL);
        pending_values = '{64'hABCD_EF01_2345_6789, 64'd0};
        start_phase(6'd16, 6'h00, 6'h01, 1'b0, PACE_FULL);
        pending_values.push_back(64'h0000_0000_00FE_DCBA);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            sel = $urandom_range(0, 9);
            if (sel < 2) begin
                rdx = itra_pkg::RADIX_RESET;
            end else if (sel == 2) begin
                rdx = itra_pkg::CFG_DATA_W'($urandom_range(0, 63));
            end else begin
                rdx = itra_pkg::CFG_DATA_W'($urandom_range(2, 36));
            end
            start_phase(rdx, itra_pkg::CFG_DATA_W'($urandom),
                        itra_pkg::CFG_DATA_W'($urandom),
                        $urandom_range(0, 3) == 0,
                        (ph % 3 == 0) ? PACE_FULL : PACE_RANDOM);
            // Hold the result side so the core backs up and stalls its input
            if (ph == 4) begin
                hold_token++;
            end
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                kind = $urandom_range(0, 9);
                v    = {$urandom, $urandom};
                if (kind < 4) begin
                    v = v >> $urandom_range(0, 63);
                end else if (kind < 6) begin
                    v = itra_pkg::VALUE_PORT_W'($urandom_range(0, 1000));
                end else if (kind == 6) begin
                    v = {itra_pkg::VALUE_PORT_W{1'b1}} >> $urandom_range(0, 63);
                end
                pending_values.push_back(v);
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        $display("Converted %0d values over %0d setting phases: radix 0..63, both cases,",
                 values_sent, phases);
        $display("prefix on and off; %0d characters and %0d register writes, %0d mismatches",
                 chars_seen, reg_writes, mismatches);
        if (mismatches == 0) begin
            $display("tb_integer_to_radix_ascii_core OK");
        end else begin
            $display("tb_integer_to_radix_ascii_core NOT OK");
        end
        $finish;
    end

endmodule
